// File: rtl/msw_pkg.sv
package msw_pkg;

    // Field widths of the stream payloads
    localparam int REQ_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Output tdata: max_value, max_valid, padded to whole bytes
    localparam int M_TDATA_W = ((DATA_W + 1 + 7) / 8) * 8;
    // Output tuser: status, is_query
    localparam int M_TUSER_W = STATUS_W + 1;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request codes; the unused code is handled as a query
    localparam req_t REQ_PUSH  = 2'd0;
    localparam req_t REQ_POP   = 2'd1;
    localparam req_t REQ_QUERY = 2'd2;

    // Status codes
    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_PUSH_FULL   = 2'd1;
    localparam status_t ST_POP_EMPTY   = 2'd2;
    localparam status_t ST_QUERY_EMPTY = 2'd3;

endpackage

// File: rtl/msw_ram.sv
// Simple dual-port RAM, one write port, one read port, registered read.
module msw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/stack_with_running_maximum.sv
// Channel | Dir | Handshake         | tdata (low bit up)              | tuser (low bit up)
// s_      | in  | s_tvalid/s_tready | [31:0] push_value               | [1:0] req_type
// m_      | out | m_tvalid/m_tready | [31:0] max_value, [32] max_valid| [1:0] status, [2] is_query
//
// One transaction in, one transaction out. A request is held in the input
// register, is executed against the stack state and lands in the result register;
// one request per cycle is sustained while m_tready stays high.
// The next top-of-stack maximum is kept prefetched from the RAM (registered read),
// so a pop need not wait for the RAM. Reset (aresetn, synchronous) empties the stack at
// once; the RAM is not cleared. A stall on m_ holds the result and, one request
// later, the input register, and then s_tready drops.
module stack_with_running_maximum
    import msw_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] push_value
    input  logic [REQ_W-1:0]     s_tuser,   // [1:0] req_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] max_value, [32] max_valid, zero pad
    output logic [M_TUSER_W-1:0] m_tuser    // [1:0] status, [2] is_query
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef logic [DATA_W-1:0]  value_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    // Input register
    logic              in_valid_reg;
    req_t              in_req_reg;
    logic [DATA_W-1:0] in_value_reg;

    // Stack state: depth and the running maximum of the top entry
    depth_t depth_reg, depth_next;
    value_t top_max_reg, top_max_next;

    // Result register
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] res_max_reg;
    logic              res_valid_reg;
    status_t           res_status_reg;
    logic              res_query_reg;

    // Datapath
    logic              exec;
    logic              full;
    logic              empty;
    value_t            push_val;
    value_t            push_max;
    depth_t            op_depth;
    value_t            op_top;
    status_t           op_status;
    logic              op_query;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    value_t            rd_data;

    // Execute when a request is held and the result slot is free or draining
    assign exec     = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || exec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg   <= s_tuser;
            in_value_reg <= s_tdata;
        end
    end

    assign full     = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign empty    = (depth_reg == '0);
    assign push_val = in_value_reg;
    assign push_max = (!empty && (top_max_reg > push_val)) ? top_max_reg : push_val;

    always_comb begin
        op_depth  = depth_reg;
        op_top    = top_max_reg;
        op_status = ST_OK;
        op_query  = 1'b0;
        unique case (in_req_reg)
            REQ_PUSH: begin
                if (full) begin
                    op_status = ST_PUSH_FULL;
                end else begin
                    op_depth = depth_reg + DEPTH_W'(1);
                    op_top   = push_max;
                end
            end
            REQ_POP: begin
                if (empty) begin
                    op_status = ST_POP_EMPTY;
                end else begin
                    op_depth = depth_reg - DEPTH_W'(1);
                    // rd_data holds the running max one below the top
                    op_top   = (depth_reg != DEPTH_W'(1)) ? rd_data : '0;
                end
            end
            default: begin
                // query, and the unused code treated as one
                op_query = 1'b1;
                if (empty) begin
                    op_status = ST_QUERY_EMPTY;
                end
            end
        endcase
    end

    assign depth_next   = exec ? op_depth : depth_reg;
    assign top_max_next = exec ? op_top : top_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            top_max_reg <= '0;
        end else begin
            depth_reg   <= depth_next;
            top_max_reg <= top_max_next;
        end
    end

    // Store the running max at the new top; prefetch the entry below the next top
    assign wr_en   = exec && (in_req_reg == REQ_PUSH) && !full;
    assign wr_addr = ADDR_W'(depth_reg);
    assign rd_addr = (depth_next >= DEPTH_W'(2)) ? ADDR_W'(depth_next - DEPTH_W'(2)) : '0;

    msw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_max),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            res_max_reg    <= op_top;
            res_valid_reg  <= (op_depth != '0);
            res_status_reg <= op_status;
            res_query_reg  <= op_query;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({res_valid_reg, res_max_reg});
    assign m_tuser  = {res_query_reg, res_status_reg};

    // Checks
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (depth_reg == '0) |-> (top_max_reg == '0))
        else $error("running max not cleared on empty stack");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (depth_reg == $past(depth_reg) + DEPTH_W'(1)))
        else $error("push did not grow the stack");

    a_push_max_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !empty) |=> (top_max_reg >= $past(top_max_reg)))
        else $error("running max dropped on push");

    a_result_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !res_valid_reg) |-> (res_max_reg == '0))
        else $error("nonzero maximum reported for empty stack");

endmodule
